@@ hw/rtl/wc2d_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the 2-D window correlation core.
package wc2d_pkg;

    localparam int PIX_W   = 16;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = PIX_W + COEF_W;
    localparam int OUT_W   = 38;
    localparam int OCOL_W  = 10;
    localparam int CFG_W   = 11;
    localparam int CIDX_W  = 7;
    localparam int TAPS_W  = 4;

    localparam logic KIND_COEFF = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        CFG_PADDED_WIDTH = 2'd0,
        CFG_OUTPUT_WIDTH = 2'd1,
        CFG_TAPS_ACROSS  = 2'd2,
        CFG_TAPS_DOWN    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic              emit;
        logic [OCOL_W-1:0] out_col;
        logic              row_last;
    } meta_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered;
        logic [OCOL_W-1:0]       out_col;
        logic                    row_last;
    } out_item_t;

endpackage

@@ hw/rtl/wc2d_mac.sv @@
`timescale 1ns / 1ps
// Parallel tap multipliers followed by a registered binary adder tree.
module wc2d_mac #(
    parameter int NT   = 81,
    parameter int SUMW = 39
) (
    input  logic                                 aclk,
    input  logic signed [wc2d_pkg::PIX_W-1:0]    win  [0:NT-1],
    input  logic signed [wc2d_pkg::COEF_W-1:0]   coef [0:NT-1],
    output logic signed [SUMW-1:0]               sum
);
    localparam int L  = (NT > 1) ? $clog2(NT) : 0;
    localparam int NP = 1 << L;

    logic signed [SUMW-1:0] sum_reg [1:2*NP-1];

    genvar i;
    generate
        for (i = 1; i < 2*NP; i++) begin : g_node
            if (i >= NP + NT) begin : g_pad
                always_ff @(posedge aclk) begin
                    sum_reg[i] <= '0;
                end
            end else if (i >= NP) begin : g_leaf
                logic signed [wc2d_pkg::PROD_W-1:0] prod;
                assign prod = win[i-NP] * coef[i-NP];
                always_ff @(posedge aclk) begin
                    sum_reg[i] <= SUMW'(prod);
                end
            end else begin : g_add
                always_ff @(posedge aclk) begin
                    sum_reg[i] <= sum_reg[2*i] + sum_reg[2*i+1];
                end
            end
        end
    endgenerate

    assign sum = sum_reg[1];

endmodule

@@ hw/rtl/window_correlation_2d_core.sv @@
`timescale 1ns / 1ps
// Top level of the 2-D valid correlation core: counters, line memory, window, output queue.
//
// Takes one request per cycle, coefficient loads and pixels alike, while neither the
// coefficient pass nor a full output queue holds the input off, and multiplies all window
// taps in parallel. A pixel result passes through the line-memory read, the window
// registers, the multipliers and the adder tree. The line memory holds one word per
// column with all buffered rows, read and written once per pixel, with forwarding for
// back-to-back requests on the same column. Any configuration write starts a pass that
// maps the stored coefficients onto the window taps; no request is taken during it.
// A small output queue lets the input keep flowing while results wait to be taken.
module window_correlation_2d_core #(
    parameter int MAX_TAPS_ACROSS = 9,
    parameter int MAX_TAPS_DOWN   = 9,
    parameter int MAX_LINE        = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // coeff_index[6:0], coeff_value[22:7], sample[38:23]
    input  logic [1:0]  s_axis_tuser,   // kind[0], frame_start[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // filtered[37:0], out_col[47:38]
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [wc2d_pkg::CFG_W-1:0] cfg_wr_data
);
    localparam int MTA   = MAX_TAPS_ACROSS;
    localparam int MTD   = MAX_TAPS_DOWN;
    localparam int NT    = MTA * MTD;
    localparam int KW    = (NT > 1) ? $clog2(NT) : 1;
    localparam int L     = (NT > 1) ? $clog2(NT) : 0;
    localparam int SUMW  = wc2d_pkg::PROD_W + L + 1;
    localparam int LROWS = (MTD > 1) ? MTD - 1 : 1;
    localparam int LWW   = LROWS * wc2d_pkg::PIX_W;
    localparam int AW    = $clog2(MAX_LINE);
    localparam int CW    = $clog2(MAX_LINE + 1);
    localparam int RW    = (MTD > 1) ? $clog2(MTD) : 1;
    localparam int MD    = L + 2;
    localparam int FD    = 1 << $clog2(L + 4);
    localparam int FAW   = $clog2(FD);
    localparam int PW    = wc2d_pkg::PIX_W;

    // configuration
    logic [wc2d_pkg::CFG_W-1:0]  pw_reg, ow_reg;
    logic [wc2d_pkg::TAPS_W-1:0] ta_reg, td_reg;
    logic [31:0] pw32, ow32, ta32, td32;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_reg <= wc2d_pkg::CFG_W'(1024);
            ow_reg <= wc2d_pkg::CFG_W'(1016);
            ta_reg <= wc2d_pkg::TAPS_W'(9);
            td_reg <= wc2d_pkg::TAPS_W'(9);
        end else if (cfg_wr_en) begin
            case (wc2d_pkg::cfg_idx_t'(cfg_addr))
                wc2d_pkg::CFG_PADDED_WIDTH: pw_reg <= cfg_wr_data;
                wc2d_pkg::CFG_OUTPUT_WIDTH: ow_reg <= cfg_wr_data;
                wc2d_pkg::CFG_TAPS_ACROSS:  ta_reg <= cfg_wr_data[wc2d_pkg::TAPS_W-1:0];
                wc2d_pkg::CFG_TAPS_DOWN:    td_reg <= cfg_wr_data[wc2d_pkg::TAPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        pw32 = 32'(pw_reg);
        if (pw32 == 32'd0 || pw32 > 32'(MAX_LINE)) pw32 = 32'(MAX_LINE);
        ow32 = 32'(ow_reg);
        ta32 = 32'(ta_reg);
        if (ta32 == 32'd0) ta32 = 32'd1;
        else if (ta32 > 32'(MTA)) ta32 = 32'(MTA);
        td32 = 32'(td_reg);
        if (td32 == 32'd0) td32 = 32'd1;
        else if (td32 > 32'(MTD)) td32 = 32'(MTD);
    end

    // request decode
    logic acc, acc_px, acc_ld;
    logic [wc2d_pkg::CIDX_W-1:0] in_idx;
    logic signed [PW-1:0] in_coef, in_sample;
    logic in_fs;
    logic rb_active_reg;
    logic [FAW:0] occ_reg;

    assign in_idx    = s_axis_tdata[6:0];
    assign in_coef   = s_axis_tdata[22:7];
    assign in_sample = s_axis_tdata[38:23];
    assign in_fs     = s_axis_tuser[1];
    assign s_axis_tready = !rb_active_reg && (occ_reg < (FAW+1)'(FD));
    assign acc    = s_axis_tvalid && s_axis_tready;
    assign acc_px = acc && (s_axis_tuser[0] == wc2d_pkg::KIND_PIXEL);
    assign acc_ld = acc && (s_axis_tuser[0] == wc2d_pkg::KIND_COEFF);

    // column / row tracking
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [31:0] col32, row32, ocol32;
    logic emit_w, last_w;

    always_comb begin
        col32 = in_fs ? 32'd0 : 32'(col_reg);
        row32 = in_fs ? 32'd0 : 32'(row_reg);
        if (col32 >= pw32) col32 = 32'd0;
        ocol32 = col32 - ta32 + 32'd1;
        emit_w = (col32 >= ta32 - 32'd1) && (row32 >= td32 - 32'd1) && (ocol32 < ow32);
        last_w = (ocol32 + 32'd1 == ow32) || (col32 + 32'd1 == pw32);
        col_next = CW'(col32 + 32'd1);
        row_next = RW'(row32);
        if (col32 + 32'd1 >= pw32) begin
            col_next = '0;
            if (row32 < 32'(MTD - 1)) row_next = RW'(row32 + 32'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (acc_px) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1: line memory read
    logic [LWW-1:0] line_mem [0:MAX_LINE-1];
    logic [LWW-1:0] mem_q_reg, fwd_word_reg, rd_word, wr_word;
    logic           fwd_reg;
    logic           s1_v_reg;
    logic [AW-1:0]  col1_reg, rd_addr;
    logic signed [PW-1:0] s1_reg;
    wc2d_pkg::meta_t m1_reg;

    assign rd_addr = AW'(col32);
    assign rd_word = fwd_reg ? fwd_word_reg : mem_q_reg;

    genvar gk;
    generate
        for (gk = 0; gk < LROWS; gk++) begin : g_age
            if (gk == 0) begin : g_first
                assign wr_word[PW-1:0] = s1_reg;
            end else begin : g_rest
                assign wr_word[gk*PW +: PW] = rd_word[(gk-1)*PW +: PW];
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        mem_q_reg    <= line_mem[rd_addr];
        fwd_word_reg <= wr_word;
        col1_reg     <= rd_addr;
        s1_reg       <= in_sample;
        m1_reg       <= '{emit: emit_w, out_col: wc2d_pkg::OCOL_W'(ocol32), row_last: last_w};
        if (s1_v_reg) line_mem[col1_reg] <= wr_word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            fwd_reg  <= 1'b0;
        end else begin
            s1_v_reg <= acc_px;
            fwd_reg  <= s1_v_reg && (col1_reg == rd_addr);
        end
    end

    // window registers
    logic signed [PW-1:0] win_reg [0:NT-1];

    genvar gr, gc;
    generate
        for (gr = 0; gr < MTD; gr++) begin : g_wr
            for (gc = 0; gc < MTA; gc++) begin : g_wc
                logic signed [PW-1:0] w_in;
                if (gc < MTA - 1) begin : g_shift
                    assign w_in = win_reg[gr*MTA + gc + 1];
                end else if (gr == MTD - 1) begin : g_pix
                    assign w_in = s1_reg;
                end else begin : g_line
                    assign w_in = rd_word[(MTD-2-gr)*PW +: PW];
                end
                always_ff @(posedge aclk) begin
                    if (!aresetn) win_reg[gr*MTA + gc] <= '0;
                    else if (s1_v_reg) win_reg[gr*MTA + gc] <= w_in;
                end
            end
        end
    endgenerate

    // coefficient store and per-tap coefficients
    logic signed [PW-1:0] coef_mem [0:NT-1];
    logic signed [PW-1:0] coef_q_reg;
    logic [KW:0]          rb_addr_reg;
    logic [KW-1:0]        rb_waddr_reg;
    logic                 rb_dv_reg;
    logic                 ld_v_reg;
    logic [KW-1:0]        ld_idx_reg;
    logic signed [PW-1:0] ld_val_reg;
    logic                 tw_v;
    logic [KW-1:0]        tw_idx;
    logic signed [PW-1:0] tw_val;

    assign tw_v   = ld_v_reg || rb_dv_reg;
    assign tw_idx = ld_v_reg ? ld_idx_reg : rb_waddr_reg;
    assign tw_val = ld_v_reg ? ld_val_reg : coef_q_reg;

    always_ff @(posedge aclk) begin
        coef_q_reg   <= coef_mem[rb_addr_reg[KW-1:0]];
        rb_waddr_reg <= rb_addr_reg[KW-1:0];
        ld_idx_reg   <= KW'(in_idx);
        ld_val_reg   <= in_coef;
        if (ld_v_reg) coef_mem[ld_idx_reg] <= ld_val_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ld_v_reg      <= 1'b0;
            rb_active_reg <= 1'b0;
            rb_addr_reg   <= '0;
            rb_dv_reg     <= 1'b0;
        end else begin
            ld_v_reg <= acc_ld && (32'(in_idx) < 32'(NT));
            if (cfg_wr_en) begin
                rb_active_reg <= 1'b1;
                rb_addr_reg   <= '0;
                rb_dv_reg     <= 1'b0;
            end else if (rb_active_reg) begin
                if (32'(rb_addr_reg) < 32'(NT)) begin
                    rb_dv_reg   <= 1'b1;
                    rb_addr_reg <= rb_addr_reg + 1'b1;
                end else begin
                    rb_dv_reg     <= 1'b0;
                    rb_active_reg <= 1'b0;
                end
            end else begin
                rb_dv_reg <= 1'b0;
            end
        end
    end

    logic signed [PW-1:0] tapc_reg [0:NT-1];
    logic signed [PW-1:0] coef_g   [0:NT-1];
    logic signed [PW-1:0] win_g    [0:NT-1];

    generate
        for (gr = 0; gr < MTD; gr++) begin : g_tr
            for (gc = 0; gc < MTA; gc++) begin : g_tc
                logic          inkern_reg;
                logic [KW-1:0] kidx_reg;
                logic [31:0]   k32;
                assign k32 = (32'(gr) + td32 - 32'(MTD)) * ta32 + 32'(gc) + ta32 - 32'(MTA);
                always_ff @(posedge aclk) begin
                    inkern_reg <= (32'(gr) + td32 >= 32'(MTD)) &&
                                  (32'(gc) + ta32 >= 32'(MTA));
                    kidx_reg   <= KW'(k32);
                    if (tw_v && inkern_reg && kidx_reg == tw_idx)
                        tapc_reg[gr*MTA + gc] <= tw_val;
                end
                assign coef_g[gr*MTA + gc] = inkern_reg ? tapc_reg[gr*MTA + gc] : '0;
                assign win_g[gr*MTA + gc]  = inkern_reg ? win_reg[gr*MTA + gc] : '0;
            end
        end
    endgenerate

    // multiply and sum
    logic signed [SUMW-1:0] sum;

    wc2d_mac #(
        .NT   (NT),
        .SUMW (SUMW)
    ) u_mac (
        .aclk (aclk),
        .win  (win_g),
        .coef (coef_g),
        .sum  (sum)
    );

    // result tracking alongside the datapath
    wc2d_pkg::meta_t meta_reg [0:MD-1];

    genvar gm;
    generate
        for (gm = 0; gm < MD; gm++) begin : g_meta
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    meta_reg[gm] <= '0;
                end else if (gm == 0) begin
                    meta_reg[gm] <= '{emit:     s1_v_reg && m1_reg.emit,
                                      out_col:  m1_reg.out_col,
                                      row_last: m1_reg.row_last};
                end else begin
                    meta_reg[gm] <= meta_reg[(gm > 0) ? gm - 1 : 0];
                end
            end
        end
    endgenerate

    // output queue
    wc2d_pkg::out_item_t fifo_mem [0:FD-1];
    wc2d_pkg::out_item_t head;
    logic [FAW-1:0] wptr_reg, rptr_reg;
    logic [FAW:0]   fcnt_reg;
    logic push, pop;

    assign push = meta_reg[MD-1].emit;
    assign pop  = m_axis_tvalid && m_axis_tready;
    assign head = fifo_mem[rptr_reg];
    assign m_axis_tvalid = (fcnt_reg != '0);
    assign m_axis_tdata  = {head.out_col, head.filtered};
    assign m_axis_tlast  = head.row_last;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wptr_reg] <= '{filtered: wc2d_pkg::OUT_W'(sum),
                                    out_col:  meta_reg[MD-1].out_col,
                                    row_last: meta_reg[MD-1].row_last};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fcnt_reg <= '0;
            occ_reg  <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            fcnt_reg <= fcnt_reg + (FAW+1)'(push) - (FAW+1)'(pop);
            occ_reg  <= occ_reg + (FAW+1)'(acc_px && emit_w) - (FAW+1)'(pop);
        end
    end

endmodule

@@ tb/window_correlation_2d_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for window_correlation_2d_core: directed table, then random frames checked against a predictor.
module window_correlation_2d_core_tb;

    localparam int NT         = 81;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 30;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [wc2d_pkg::CFG_W-1:0] cfg_wr_data;

    window_correlation_2d_core DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // shadow of the block
    logic signed [15:0] line_mem [0:7][0:1023];
    logic signed [15:0] coef_mem [0:NT-1];
    logic signed [15:0] win_regs [0:NT-1];
    int unsigned col_cnt, row_cnt;
    logic [10:0] pw_reg, ow_reg;
    logic [3:0]  ta_reg, td_reg;

    wc2d_pkg::out_item_t pending_sums[$];
    int errors, items_sent, cycles;
    bit calm;

    typedef struct {
        bit                   is_cfg;
        wc2d_pkg::cfg_idx_t   addr;
        logic [10:0]          val;
        logic                 kind;
        logic [6:0]           idx;
        logic signed [15:0]   value;
        logic signed [15:0]   sample;
        logic                 fs;
        bit                   has_exp;
        wc2d_pkg::out_item_t  exp;
    } row_t;

    row_t plan[$];

    function automatic int clamp_taps(input logic [3:0] t);
        if (t == 0) return 1;
        if (t > 9) return 9;
        return t;
    endfunction

    task automatic model_pixel(input logic signed [15:0] s, input logic fs,
                               output bit hit, output wc2d_pkg::out_item_t res);
        int pw, ta, td, col, i;
        longint acc;
        if (fs) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        pw = pw_reg;
        if (pw == 0 || pw > 1024) pw = 1024;
        ta = clamp_taps(ta_reg);
        td = clamp_taps(td_reg);
        col = col_cnt;
        if (col >= pw) col = 0;
        for (int rw = 0; rw < 9; rw++)
            for (int cl = 0; cl < 8; cl++)
                win_regs[rw*9+cl] = win_regs[rw*9+cl+1];
        win_regs[80] = s;
        for (int k = 0; k < 8; k++) win_regs[(7-k)*9+8] = line_mem[k][col];
        for (int k = 7; k >= 1; k--) line_mem[k][col] = line_mem[k-1][col];
        line_mem[0][col] = s;
        hit = 0;
        res = '0;
        if (col >= ta - 1 && row_cnt >= td - 1) begin
            i = col - (ta - 1);
            if (i < ow_reg) begin
                acc = 0;
                for (int dr = 0; dr < td; dr++)
                    for (int dc = 0; dc < ta; dc++)
                        acc += longint'(win_regs[(9-td+dr)*9 + 9-ta+dc])
                             * longint'(coef_mem[dr*ta+dc]);
                res.filtered = acc[37:0];
                res.out_col  = i[9:0];
                res.row_last = (i + 1 == ow_reg) || (col + 1 == pw);
                hit = 1;
            end
        end
        col++;
        if (col >= pw) begin
            col = 0;
            if (row_cnt < 8) row_cnt++;
        end
        col_cnt = col;
    endtask

    // one request; called right after a falling edge
    task automatic send_item(input logic kind, input logic [6:0] idx,
                             input logic signed [15:0] value, input logic signed [15:0] s,
                             input logic fs, input bit has_exp,
                             input wc2d_pkg::out_item_t exp);
        bit hit;
        wc2d_pkg::out_item_t res;
        while (!calm && $urandom_range(99) < 30) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tdata  = {1'b0, s, value, idx};
        s_axis_tuser  = {fs, kind};
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
        if (kind == wc2d_pkg::KIND_COEFF) begin
            if (idx < NT) coef_mem[idx] = value;
        end else begin
            model_pixel(s, fs, hit, res);
            if (has_exp) pending_sums.push_back(exp);
            else if (hit) pending_sums.push_back(res);
        end
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic write_reg(input wc2d_pkg::cfg_idx_t a, input logic [10:0] v);
        while (pending_sums.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_addr    = a;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (a)
            wc2d_pkg::CFG_PADDED_WIDTH: pw_reg = v;
            wc2d_pkg::CFG_OUTPUT_WIDTH: ow_reg = v;
            wc2d_pkg::CFG_TAPS_ACROSS:  ta_reg = v[3:0];
            default:                    td_reg = v[3:0];
        endcase
    endtask

    task automatic load_coeffs(input bit fixed, input logic signed [15:0] v);
        for (int k = 0; k < NT; k++)
            send_item(wc2d_pkg::KIND_COEFF, k[6:0], fixed ? v : 16'($urandom), '0, 1'b0, 0,
                      '0);
    endtask

    // one setting, then a run of pixels with some coefficient loads mixed in
    task automatic run_phase(input int pw, input int ow, input int ta, input int td,
                             input int npix, input bit fs_first, input int cf_pct);
        write_reg(wc2d_pkg::CFG_PADDED_WIDTH, pw[10:0]);
        write_reg(wc2d_pkg::CFG_OUTPUT_WIDTH, ow[10:0]);
        write_reg(wc2d_pkg::CFG_TAPS_ACROSS, ta[10:0]);
        write_reg(wc2d_pkg::CFG_TAPS_DOWN, td[10:0]);
        for (int n = 0; n < npix; n++) begin
            if ($urandom_range(99) < cf_pct)
                send_item(wc2d_pkg::KIND_COEFF, 7'($urandom), 16'($urandom), 16'($urandom),
                          1'($urandom), 0, '0);
            send_item(wc2d_pkg::KIND_PIXEL, 7'($urandom), 16'($urandom), 16'($urandom),
                      (n == 0 && fs_first) || $urandom_range(199) == 0, 0, '0);
        end
    endtask

    function automatic row_t row_cfg(input wc2d_pkg::cfg_idx_t a, input logic [10:0] v);
        row_t r = '{addr: wc2d_pkg::CFG_PADDED_WIDTH, default: '0};
        r.is_cfg = 1;
        r.addr = a;
        r.val = v;
        return r;
    endfunction

    function automatic row_t row_cf(input logic [6:0] i, input logic signed [15:0] v);
        row_t r = '{addr: wc2d_pkg::CFG_PADDED_WIDTH, default: '0};
        r.kind = wc2d_pkg::KIND_COEFF;
        r.idx = i;
        r.value = v;
        return r;
    endfunction

    function automatic row_t row_px(input logic signed [15:0] s, input logic fs,
                                    input bit has, input longint f, input int c,
                                    input logic l);
        row_t r = '{addr: wc2d_pkg::CFG_PADDED_WIDTH, default: '0};
        r.kind = wc2d_pkg::KIND_PIXEL;
        r.value = 16'sh1234;
        r.sample = s;
        r.idx = 7'h55;
        r.fs = fs;
        r.has_exp = has;
        r.exp.filtered = f[37:0];
        r.exp.out_col = c[9:0];
        r.exp.row_last = l;
        return r;
    endfunction

    always @(negedge aclk)
        m_axis_tready <= calm || $urandom_range(99) >= 30;

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_sums.size() == 0) begin
                $display("%t unexpected result: filtered=%0d col=%0d last=%0b", $realtime,
                         $signed(m_axis_tdata[37:0]), m_axis_tdata[47:38], m_axis_tlast);
                errors++;
            end else begin
                wc2d_pkg::out_item_t e;
                e = pending_sums.pop_front();
                if (m_axis_tdata[37:0] !== e.filtered || m_axis_tdata[47:38] !== e.out_col
                        || m_axis_tlast !== e.row_last) begin
                    $display("%t mismatch: expected filtered=%0d col=%0d last=%0b, got %0d %0d %0b",
                             $realtime, e.filtered, e.out_col, e.row_last,
                             $signed(m_axis_tdata[37:0]), m_axis_tdata[47:38], m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("window_correlation_2d_core verification failed");
            $finish;
        end
    end

    initial begin
        int pw, td;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wr_data = '0;
        errors = 0;
        items_sent = 0;
        cycles = 0;
        calm = 0;
        for (int k = 0; k < NT; k++) win_regs[k] = '0;
        col_cnt = 0;
        row_cnt = 0;
        pw_reg = 11'd1024;
        ow_reg = 11'd1016;
        ta_reg = 4'd9;
        td_reg = 4'd9;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        plan.push_back(row_cfg(wc2d_pkg::CFG_PADDED_WIDTH, 11'd4));
        plan.push_back(row_cfg(wc2d_pkg::CFG_OUTPUT_WIDTH, 11'd4));
        plan.push_back(row_cfg(wc2d_pkg::CFG_TAPS_ACROSS, 11'd1));
        plan.push_back(row_cfg(wc2d_pkg::CFG_TAPS_DOWN, 11'd1));
        plan.push_back(row_cf(7'd0, 16'sh7fff));
        plan.push_back(row_px(-16'sd32768, 1'b1, 1, -64'sd1073709056, 0, 1'b0));
        plan.push_back(row_cf(7'd0, -16'sd32768));
        plan.push_back(row_px(-16'sd32768, 1'b0, 1, 64'sd1073741824, 1, 1'b0));
        plan.push_back(row_px(16'sh7fff, 1'b0, 1, -64'sd1073709056, 2, 1'b0));
        plan.push_back(row_px(16'sd0, 1'b0, 1, 64'sd0, 3, 1'b1));
        plan.push_back(row_cf(7'd81, 16'sd5));
        plan.push_back(row_cf(7'd127, -16'sd1));
        plan.push_back(row_px(16'sd1, 1'b0, 1, -64'sd32768, 0, 1'b0));
        plan.push_back(row_cfg(wc2d_pkg::CFG_OUTPUT_WIDTH, 11'd2));
        plan.push_back(row_px(16'sd2, 1'b0, 1, -64'sd65536, 1, 1'b1));
        plan.push_back(row_px(16'sd3, 1'b0, 0, 0, 0, 1'b0));
        plan.push_back(row_px(-16'sd1, 1'b1, 1, 64'sd32768, 0, 1'b0));
        foreach (plan[n]) begin
            if (plan[n].is_cfg) write_reg(plan[n].addr, plan[n].val);
            else send_item(plan[n].kind, plan[n].idx, plan[n].value, plan[n].sample,
                           plan[n].fs, plan[n].has_exp, plan[n].exp);
        end

        // largest sum: full 9x9 window of -32768 times -32768
        calm = 1;
        load_coeffs(1, -16'sd32768);
        write_reg(wc2d_pkg::CFG_PADDED_WIDTH, 11'd9);
        write_reg(wc2d_pkg::CFG_OUTPUT_WIDTH, 11'd1);
        write_reg(wc2d_pkg::CFG_TAPS_ACROSS, 11'd9);
        write_reg(wc2d_pkg::CFG_TAPS_DOWN, 11'd9);
        for (int n = 0; n < 81; n++)
            send_item(wc2d_pkg::KIND_PIXEL, '0, '0, -16'sd32768, n == 0, n == 80,
                      '{filtered: 38'sd86973087744, out_col: '0, row_last: 1'b1});
        calm = 0;
        load_coeffs(0, '0);

        run_phase(0, 2047, 3, 0, 40, 1, 5);
        run_phase(2000, 5, 15, 1, 40, 1, 5);
        run_phase(1, 1, 1, 1, 12, 1, 0);
        run_phase(1024, 1024, 9, 1, 30, 1, 5);
        run_phase(20, 20, 3, 3, 75, 1, 5);
        run_phase(6, 6, 2, 1, 20, 0, 5);   // column past new row end restarts at zero
        run_phase(5, 0, 2, 2, 20, 1, 5);

        while (items_sent < 1150) begin
            pw = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
            td = ($urandom_range(7) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
            calm = ($urandom_range(5) == 0);
            run_phase(pw, $urandom_range(0, pw + 2), $urandom_range(0, 15), td,
                      pw * (clamp_taps(td[3:0]) + 3), 1, 8);
        end
        calm = 0;

        while (pending_sums.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0) begin
            $display("window_correlation_2d_core verification clean");
        end else begin
            $display("window_correlation_2d_core verification failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/wc2d_pkg.sv
hw/rtl/wc2d_mac.sv
hw/rtl/window_correlation_2d_core.sv
tb/window_correlation_2d_core_tb.sv
